/* sv/hill_cipher_2x2_mod26_defines.svh */
// Assertion macros shared by the Hill cipher RTL.
`ifndef HILL_CIPHER_2X2_MOD26_DEFINES_SVH
`define HILL_CIPHER_2X2_MOD26_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define HC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hill cipher assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define HC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hill cipher assertion failed");

`endif

/* sv/hc_pkg.sv */
// Types, constants and arithmetic helpers for the Hill cipher block.
`default_nettype none
package hc_pkg;

    localparam int unsigned LETTER_W   = 5;
    localparam int unsigned PROD_W     = 10;
    localparam int unsigned SUM_W      = 11;
    localparam int unsigned REG_IDX_W  = 2;
    localparam int unsigned SETTLE_W   = 3;

    typedef logic [LETTER_W-1:0]  t_letter;
    typedef logic [PROD_W-1:0]    t_prod;
    typedef logic [SUM_W-1:0]     t_sum;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_letter LETTERS    = 5'd26;
    localparam t_letter PAD_LETTER = 5'd23;
    localparam t_sum    LETTERS_SQ = 11'd676;
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 3'd6;

    localparam t_reg_idx REG_K00 = 2'd0;
    localparam t_reg_idx REG_K01 = 2'd1;
    localparam t_reg_idx REG_K10 = 2'd2;
    localparam t_reg_idx REG_K11 = 2'd3;

    localparam t_letter K00_RESET = 5'd1;
    localparam t_letter K01_RESET = 5'd0;
    localparam t_letter K10_RESET = 5'd0;
    localparam t_letter K11_RESET = 5'd1;

    // Matrix entries in the order row0col0, row0col1, row1col0, row1col1.
    typedef logic [3:0][LETTER_W-1:0] t_mat;

    typedef struct packed {
        t_mat enc;
        t_mat dec;
        logic singular;
        logic settled;
    } t_key_mats;

    typedef struct packed {
        logic s1_en;
        logic s2_en;
    } t_lane_ctrl;

    // One conditional subtract brings a 5-bit value into 0..25.
    function automatic t_letter reduce5(input t_letter v);
        return (v >= LETTERS) ? t_letter'(v - LETTERS) : v;
    endfunction

    // Remainder by 26 through the reciprocal 315/8192; the quotient estimate is
    // never too large and at most one short, so one correction step follows.
    function automatic t_letter mod26(input t_sum v);
        logic [19:0] prod;
        logic [6:0]  q;
        t_sum        r;
        prod = 20'(v) * 20'd315;
        q    = prod[19:13];
        r    = v - t_sum'(11'(q) * 11'd26);
        if (r >= t_sum'(LETTERS)) begin
            r = r - t_sum'(LETTERS);
        end
        return r[LETTER_W-1:0];
    endfunction

    // Inverse of each unit modulo 26; residues without an inverse give zero.
    function automatic t_letter unit_inverse(input t_letter d);
        t_letter inv;
        case (d)
            5'd1:    inv = 5'd1;
            5'd3:    inv = 5'd9;
            5'd5:    inv = 5'd21;
            5'd7:    inv = 5'd15;
            5'd9:    inv = 5'd3;
            5'd11:   inv = 5'd19;
            5'd15:   inv = 5'd7;
            5'd17:   inv = 5'd23;
            5'd19:   inv = 5'd11;
            5'd21:   inv = 5'd5;
            5'd23:   inv = 5'd17;
            5'd25:   inv = 5'd25;
            default: inv = 5'd0;
        endcase
        return inv;
    endfunction

endpackage
`default_nettype wire

/* sv/hc_if.sv */
// Valid/ready channel interfaces for letter pairs, results and key writes.
`default_nettype none
interface hc_pair_if;
    import hc_pkg::*;
    logic    valid;
    logic    ready;
    logic    operation;
    t_letter first_letter;
    t_letter second_letter;
    logic    second_missing;

    modport source (output valid, operation, first_letter, second_letter, second_missing,
                    input ready);
    modport sink   (input valid, operation, first_letter, second_letter, second_missing,
                    output ready);
endinterface

interface hc_res_if;
    import hc_pkg::*;
    logic    valid;
    logic    ready;
    t_letter first_out;
    t_letter second_out;
    logic    key_not_invertible;

    modport source (output valid, first_out, second_out, key_not_invertible, input ready);
    modport sink   (input valid, first_out, second_out, key_not_invertible, output ready);
endinterface

interface hc_cfg_if;
    import hc_pkg::*;
    logic     valid;
    logic     ready;
    t_reg_idx reg_index;
    t_letter  wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface
`default_nettype wire

/* sv/hc_keygen.sv */
// Key registers and the pipelined derivation of the inverse key matrix.
`default_nettype none
module hc_keygen (
    input  wire               i_clk,
    input  wire               i_rst_n,
    hc_cfg_if.sink            i_cfg,
    output hc_pkg::t_key_mats o_mats
);
    import hc_pkg::*;

    t_letter r_k00, r_k01, r_k10, r_k11;
    t_mat    r_kr;
    t_letter r_neg01, r_neg10;
    t_mat    r_kr2;
    t_letter r_neg01_2, r_neg10_2;
    t_prod   r_p0, r_p1;
    t_mat    r_kr3;
    t_letter r_neg01_3, r_neg10_3;
    t_letter r_det;
    t_mat    r_kr4;
    t_letter r_inv;
    logic    r_singular;
    t_prod   r_m00p, r_m01p, r_m10p, r_m11p;
    logic    r_singular5;
    t_mat    r_dec;
    logic    r_singular6;
    logic [SETTLE_W-1:0] r_settle;
    logic [SETTLE_W-1:0] n_settle;
    logic    wr_fire;

    assign i_cfg.ready = 1'b1;
    assign wr_fire     = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k00 <= K00_RESET;
            r_k01 <= K01_RESET;
            r_k10 <= K10_RESET;
            r_k11 <= K11_RESET;
        end else if (wr_fire) begin
            case (i_cfg.reg_index)
                REG_K00: r_k00 <= i_cfg.wr_data;
                REG_K01: r_k01 <= i_cfg.wr_data;
                REG_K10: r_k10 <= i_cfg.wr_data;
                REG_K11: r_k11 <= i_cfg.wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (wr_fire) begin
            n_settle = SETTLE_CYCLES;
        end else if (r_settle != '0) begin
            n_settle = r_settle - 1'b1;
        end else begin
            n_settle = r_settle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SETTLE_CYCLES;
        end else begin
            r_settle <= n_settle;
        end
    end

    // The derivation runs freely; the settle count covers its depth.
    always_ff @(posedge i_clk) begin
        r_kr      <= {reduce5(r_k11), reduce5(r_k10), reduce5(r_k01), reduce5(r_k00)};

        r_kr2     <= r_kr;
        r_neg01   <= (r_kr[1] == '0) ? '0 : t_letter'(LETTERS - r_kr[1]);
        r_neg10   <= (r_kr[2] == '0) ? '0 : t_letter'(LETTERS - r_kr[2]);
        r_p0      <= t_prod'(r_kr[0]) * t_prod'(r_kr[3]);
        r_p1      <= t_prod'(r_kr[1]) * t_prod'(r_kr[2]);
        r_neg01_2 <= r_neg01;
        r_neg10_2 <= r_neg10;

        r_kr3     <= r_kr2;
        r_neg01_3 <= r_neg01_2;
        r_neg10_3 <= r_neg10_2;
        r_det     <= mod26(t_sum'(r_p0) + LETTERS_SQ - t_sum'(r_p1));

        r_kr4      <= r_kr3;
        r_inv      <= unit_inverse(r_det);
        r_singular <= (unit_inverse(r_det) == '0);

        // A singular key has a zero inverse, so the decrypt matrix comes out zero.
        r_m00p      <= t_prod'(r_kr4[3]) * t_prod'(r_inv);
        r_m01p      <= t_prod'(r_neg01_3) * t_prod'(r_inv);
        r_m10p      <= t_prod'(r_neg10_3) * t_prod'(r_inv);
        r_m11p      <= t_prod'(r_kr4[0]) * t_prod'(r_inv);
        r_singular5 <= r_singular;

        r_dec       <= {mod26(t_sum'(r_m11p)), mod26(t_sum'(r_m10p)),
                        mod26(t_sum'(r_m01p)), mod26(t_sum'(r_m00p))};
        r_singular6 <= r_singular5;
    end

    assign o_mats.enc      = r_kr;
    assign o_mats.dec      = r_dec;
    assign o_mats.singular = r_singular6;
    assign o_mats.settled  = (r_settle == '0);

endmodule
`default_nettype wire

/* sv/hc_lane.sv */
// One matrix row: two products, then their sum reduced modulo 26.
`default_nettype none
module hc_lane (
    input  wire                i_clk,
    input  hc_pkg::t_lane_ctrl i_ctrl,
    input  hc_pkg::t_letter    i_coef0,
    input  hc_pkg::t_letter    i_coef1,
    input  hc_pkg::t_letter    i_first,
    input  hc_pkg::t_letter    i_second,
    output hc_pkg::t_letter    o_res
);
    import hc_pkg::*;

    t_prod   r_pa;
    t_prod   r_pb;
    t_letter r_res;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.s1_en) begin
            r_pa <= t_prod'(i_coef0) * t_prod'(i_first);
            r_pb <= t_prod'(i_coef1) * t_prod'(i_second);
        end
        if (i_ctrl.s2_en) begin
            r_res <= mod26(t_sum'(r_pa) + t_sum'(r_pb));
        end
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

/* sv/hc_merge.sv */
// Output register that joins both lane results and the key flag into one beat.
`default_nettype none
module hc_merge (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    input  hc_pkg::t_letter i_row0,
    input  hc_pkg::t_letter i_row1,
    input  wire             i_flag,
    output logic            o_load,
    hc_res_if.source        o_res
);
    import hc_pkg::*;

    logic    r_valid;
    t_letter r_first;
    t_letter r_second;
    logic    r_flag;

    assign o_load = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_first  <= i_row0;
            r_second <= i_row1;
            r_flag   <= i_flag;
        end
    end

    assign o_res.valid              = r_valid;
    assign o_res.first_out          = r_first;
    assign o_res.second_out         = r_second;
    assign o_res.key_not_invertible = r_flag;

endmodule
`default_nettype wire

/* sv/hill_cipher_2x2_mod26.sv */
// Top level: 2x2 Hill cipher over letter indices modulo 26.
//
// Channels: i_pair takes one beat per letter pair (operation, first_letter,
// second_letter, second_missing); o_res returns one beat per pair with
// first_out, second_out and key_not_invertible. i_cfg writes one key entry per
// beat, reg_index 0..3 selecting row0col0, row0col1, row1col0, row1col1; it is
// always ready. Key writes belong to idle periods between traffic.
// A pair passes the lane product register, lane sum register and output register
// to reach o_res. Throughput: one pair per cycle while the key is settled and the
// receiver takes o_res beats, through this three-register pipeline.
// After reset and after each key write, i_pair.ready stays low while the inverse
// key is derived through its six-register pipeline.
// Reset returns the key to the identity matrix and empties the pipeline.
// When the receiver stalls, the output register holds its beat and earlier
// stages keep filling until no stage is free; then i_pair.ready drops.
// A lone final letter is sent with second_missing set and is padded with 'x'.
`default_nettype none
module hill_cipher_2x2_mod26 (
    input  wire      i_clk,
    input  wire      i_rst_n,
    hc_cfg_if.sink   i_cfg,
    hc_pair_if.sink  i_pair,
    hc_res_if.source o_res
);
    import hc_pkg::*;

    t_key_mats  mats;
    t_lane_ctrl lane_ctrl;
    logic       out_load;
    logic       s1_load;
    logic       s2_load;
    logic       in_fire;
    logic       r_v1, r_v2;
    logic       r_flag1, r_flag2;
    t_letter    a_red;
    t_letter    b_red;
    t_mat       coef;
    t_letter    row0, row1;

    hc_keygen u_keygen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_mats  (mats)
    );

    assign s2_load      = !r_v2 || out_load;
    assign s1_load      = !r_v1 || s2_load;
    assign i_pair.ready = s1_load && mats.settled;
    assign in_fire      = i_pair.valid && i_pair.ready;

    assign lane_ctrl.s1_en = s1_load;
    assign lane_ctrl.s2_en = s2_load;

    assign a_red = reduce5(i_pair.first_letter);
    assign b_red = i_pair.second_missing ? PAD_LETTER : reduce5(i_pair.second_letter);
    assign coef  = i_pair.operation ? mats.dec : mats.enc;

    hc_lane u_lane0 (
        .i_clk    (i_clk),
        .i_ctrl   (lane_ctrl),
        .i_coef0  (coef[0]),
        .i_coef1  (coef[1]),
        .i_first  (a_red),
        .i_second (b_red),
        .o_res    (row0)
    );

    hc_lane u_lane1 (
        .i_clk    (i_clk),
        .i_ctrl   (lane_ctrl),
        .i_coef0  (coef[2]),
        .i_coef1  (coef[3]),
        .i_first  (a_red),
        .i_second (b_red),
        .o_res    (row1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s1_load) begin
                r_v1 <= in_fire;
            end
            if (s2_load) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_flag1 <= mats.singular;
        end
        if (s2_load) begin
            r_flag2 <= r_flag1;
        end
    end

    hc_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_row0  (row0),
        .i_row1  (row1),
        .i_flag  (r_flag2),
        .o_load  (out_load),
        .o_res   (o_res)
    );

`include "hill_cipher_2x2_mod26_defines.svh"

    `HC_ASSERT_NEXT(a_accept_fills_s1, in_fire, r_v1)
    `HC_ASSERT_NEXT(a_cfg_blocks_input, i_cfg.valid && i_cfg.ready, !i_pair.ready)
    `HC_ASSERT_IMPL(a_full_blocks_input, o_res.valid && !o_res.ready && r_v2 && r_v1, !i_pair.ready)
    `HC_ASSERT_IMPL(a_out_in_range, o_res.valid, o_res.first_out < LETTERS && o_res.second_out < LETTERS)

endmodule
`default_nettype wire

/* tb/hill_cipher_2x2_mod26_tb.sv */
// Self-checking testbench for the 2x2 Hill cipher: directed table, then random key phases.
`timescale 1ns / 100ps
module hill_cipher_2x2_mod26_tb;
    import hc_pkg::*;

    localparam int ALPHABET    = 26;
    localparam int CYCLE_LIMIT = 200000;
    localparam int KEY_PHASES  = 8;
    localparam int PHASE_PAIRS = 88;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } cipher_op_e;

    typedef struct packed {
        t_letter first_out;
        t_letter second_out;
        logic    key_not_invertible;
    } cipher_res_t;

    // A row is either a key load or one letter pair, optionally with a known answer.
    typedef struct packed {
        logic        rekey;
        t_mat        key;
        cipher_op_e  op;
        t_letter     first_letter;
        t_letter     second_letter;
        logic        pad;
        logic        typed;
        cipher_res_t answer;
    } vector_t;

    logic i_clk;
    logic i_rst_n;

    hc_cfg_if  cfg_bus ();
    hc_pair_if pair_bus ();
    hc_res_if  res_bus ();

    hill_cipher_2x2_mod26 uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pair  (pair_bus),
        .o_res   (res_bus)
    );

    t_letter     key_q [4];
    cipher_res_t cipher_out_q [$];
    vector_t     vectors [$];
    cipher_res_t typed_answer;
    bit          use_typed;
    bit          idle_on;
    int          fail_count;
    int          cycle_count;
    int          stall_left;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Expected output of one pair under the key held in key_q.
    function automatic cipher_res_t cipher_pair(input cipher_op_e op, input t_letter l0,
                                                input t_letter l1, input logic pad);
        int          k [4];
        int          m [4];
        int          x;
        int          y;
        int          det;
        int          det_inv;
        cipher_res_t r;
        for (int i = 0; i < 4; i++) begin
            k[i] = int'(key_q[i]) % ALPHABET;
        end
        x = int'(l0) % ALPHABET;
        y = pad ? int'(PAD_LETTER) : int'(l1) % ALPHABET;
        det = ((k[0] * k[3] - k[1] * k[2]) % ALPHABET + ALPHABET) % ALPHABET;
        det_inv = 0;
        for (int d = 1; d < ALPHABET; d++) begin
            if ((det * d) % ALPHABET == 1) begin
                det_inv = d;
            end
        end
        if (op == OP_ENCRYPT) begin
            for (int i = 0; i < 4; i++) begin
                m[i] = k[i];
            end
        end else if (det_inv == 0) begin
            for (int i = 0; i < 4; i++) begin
                m[i] = 0;
            end
        end else begin
            // Inverse key is the adjugate scaled by the determinant's inverse.
            m[0] = (k[3] * det_inv) % ALPHABET;
            m[1] = ((ALPHABET - k[1]) * det_inv) % ALPHABET;
            m[2] = ((ALPHABET - k[2]) * det_inv) % ALPHABET;
            m[3] = (k[0] * det_inv) % ALPHABET;
        end
        r.first_out          = t_letter'((m[0] * x + m[1] * y) % ALPHABET);
        r.second_out         = t_letter'((m[2] * x + m[3] * y) % ALPHABET);
        r.key_not_invertible = (det_inv == 0);
        return r;
    endfunction

    function automatic vector_t key_row(input int k00, input int k01, input int k10,
                                        input int k11);
        vector_t v;
        v        = '0;
        v.rekey  = 1'b1;
        v.key[0] = t_letter'(k00);
        v.key[1] = t_letter'(k01);
        v.key[2] = t_letter'(k10);
        v.key[3] = t_letter'(k11);
        return v;
    endfunction

    function automatic vector_t pair_row(input cipher_op_e op, input int a, input int b,
                                         input bit pad);
        vector_t v;
        v               = '0;
        v.op            = op;
        v.first_letter  = t_letter'(a);
        v.second_letter = t_letter'(b);
        v.pad           = pad;
        return v;
    endfunction

    function automatic vector_t known_row(input cipher_op_e op, input int a, input int b,
                                          input bit pad, input int f, input int s,
                                          input bit flag);
        vector_t v;
        v = pair_row(op, a, b, pad);
        v.typed                     = 1'b1;
        v.answer.first_out          = t_letter'(f);
        v.answer.second_out         = t_letter'(s);
        v.answer.key_not_invertible = flag;
        return v;
    endfunction

    // Mostly legal letters; now and then a code of 26..31 that the block must fold.
    function automatic t_letter rand_letter();
        if ($urandom_range(0, 15) == 0) begin
            return t_letter'($urandom_range(26, 31));
        end
        return t_letter'($urandom_range(0, 25));
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_pair(input vector_t v);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            pair_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        use_typed    = v.typed;
        typed_answer = v.answer;
        pair_bus.valid          <= 1'b1;
        pair_bus.operation      <= v.op;
        pair_bus.first_letter   <= v.first_letter;
        pair_bus.second_letter  <= v.second_letter;
        pair_bus.second_missing <= v.pad;
        @(posedge i_clk);
        while (!pair_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        pair_bus.valid <= 1'b0;
        while (cipher_out_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic load_key(input t_mat k);
        t_reg_idx key_regs [4];
        key_regs = '{REG_K00, REG_K01, REG_K10, REG_K11};
        for (int i = 0; i < 4; i++) begin
            cfg_bus.valid     <= 1'b1;
            cfg_bus.reg_index <= key_regs[i];
            cfg_bus.wr_data   <= k[i];
            @(posedge i_clk);
            while (!cfg_bus.ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    // Receiver: stalls in random bursts while idling is enabled.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            res_bus.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left    <= $urandom_range(0, 2);
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cipher_res_t want;
        if (i_rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                key_q[cfg_bus.reg_index] = cfg_bus.wr_data;
            end
            // Results are checked before this edge's pair beat is queued.
            if (res_bus.valid && res_bus.ready) begin
                if (cipher_out_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected: %0d %0d %0b", $time,
                             res_bus.first_out, res_bus.second_out,
                             res_bus.key_not_invertible);
                    fail_count++;
                end else begin
                    want = cipher_out_q.pop_front();
                    if (res_bus.first_out !== want.first_out) begin
                        $display("%0t: first_out expected %0d actual %0d", $time,
                                 want.first_out, res_bus.first_out);
                        fail_count++;
                    end
                    if (res_bus.second_out !== want.second_out) begin
                        $display("%0t: second_out expected %0d actual %0d", $time,
                                 want.second_out, res_bus.second_out);
                        fail_count++;
                    end
                    if (res_bus.key_not_invertible !== want.key_not_invertible) begin
                        $display("%0t: key_not_invertible expected %0b actual %0b", $time,
                                 want.key_not_invertible, res_bus.key_not_invertible);
                        fail_count++;
                    end
                end
            end
            if (pair_bus.valid && pair_bus.ready) begin
                if (use_typed) begin
                    cipher_out_q.push_back(typed_answer);
                end else begin
                    cipher_out_q.push_back(cipher_pair(cipher_op_e'(pair_bus.operation),
                                                       pair_bus.first_letter,
                                                       pair_bus.second_letter,
                                                       pair_bus.second_missing));
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        t_mat rand_key;
        i_clk                   = 1'b0;
        i_rst_n                 = 1'b0;
        cfg_bus.valid           = 1'b0;
        cfg_bus.reg_index       = REG_K00;
        cfg_bus.wr_data         = '0;
        pair_bus.valid          = 1'b0;
        pair_bus.operation      = OP_ENCRYPT;
        pair_bus.first_letter   = '0;
        pair_bus.second_letter  = '0;
        pair_bus.second_missing = 1'b0;
        res_bus.ready           = 1'b0;
        stall_left              = 0;
        idle_on                 = 1'b1;
        use_typed               = 1'b0;
        typed_answer            = '0;
        fail_count              = 0;
        cycle_count             = 0;
        key_q = '{K00_RESET, K01_RESET, K10_RESET, K11_RESET};

        // Identity key out of reset: both modes pass letters through.
        vectors.push_back(known_row(OP_ENCRYPT, 0, 0, 0, 0, 0, 0));
        vectors.push_back(known_row(OP_ENCRYPT, 25, 25, 0, 25, 25, 0));
        vectors.push_back(known_row(OP_DECRYPT, 25, 0, 0, 25, 0, 0));
        vectors.push_back(known_row(OP_ENCRYPT, 7, 3, 1, 7, 23, 0));
        vectors.push_back(known_row(OP_DECRYPT, 12, 9, 1, 12, 23, 0));
        vectors.push_back(known_row(OP_ENCRYPT, 31, 26, 0, 5, 0, 0));
        // All-zero key is singular in both modes.
        vectors.push_back(key_row(0, 0, 0, 0));
        vectors.push_back(known_row(OP_ENCRYPT, 13, 4, 0, 0, 0, 1));
        vectors.push_back(known_row(OP_DECRYPT, 13, 4, 0, 0, 0, 1));
        vectors.push_back(key_row(25, 25, 25, 25));
        vectors.push_back(pair_row(OP_ENCRYPT, 25, 25, 0));
        vectors.push_back(known_row(OP_DECRYPT, 3, 5, 0, 0, 0, 1));
        vectors.push_back(key_row(3, 3, 2, 5));
        vectors.push_back(pair_row(OP_ENCRYPT, 7, 4, 0));
        vectors.push_back(pair_row(OP_DECRYPT, 7, 4, 0));
        vectors.push_back(pair_row(OP_ENCRYPT, 19, 7, 1));
        vectors.push_back(pair_row(OP_DECRYPT, 0, 25, 1));
        // Odd determinant 13 shares a factor with 26 and has no inverse.
        vectors.push_back(key_row(13, 0, 0, 1));
        vectors.push_back(pair_row(OP_ENCRYPT, 2, 3, 0));
        vectors.push_back(known_row(OP_DECRYPT, 2, 3, 0, 0, 0, 1));
        // Key entries above 25 are folded before use.
        vectors.push_back(key_row(31, 30, 26, 27));
        vectors.push_back(pair_row(OP_ENCRYPT, 31, 31, 0));
        vectors.push_back(pair_row(OP_DECRYPT, 30, 1, 0));
        vectors.push_back(pair_row(OP_DECRYPT, 4, 9, 1));
        vectors.push_back(key_row(25, 0, 0, 25));
        vectors.push_back(pair_row(OP_ENCRYPT, 25, 25, 0));
        vectors.push_back(pair_row(OP_DECRYPT, 1, 1, 0));
        vectors.push_back(key_row(0, 1, 1, 0));
        vectors.push_back(pair_row(OP_ENCRYPT, 5, 9, 0));
        vectors.push_back(pair_row(OP_DECRYPT, 5, 9, 1));
        vectors.push_back(key_row(2, 0, 0, 1));
        vectors.push_back(known_row(OP_DECRYPT, 9, 9, 0, 0, 0, 1));
        vectors.push_back(pair_row(OP_ENCRYPT, 9, 9, 0));

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (vectors[i]) begin
            if (vectors[i].rekey) begin
                wait_idle();
                load_key(vectors[i].key);
            end else begin
                send_pair(vectors[i]);
            end
        end

        for (int phase = 0; phase < KEY_PHASES; phase++) begin
            idle_on = (phase != KEY_PHASES - 1);
            wait_idle();
            for (int i = 0; i < 4; i++) begin
                rand_key[i] = ($urandom_range(0, 7) == 0) ? t_letter'($urandom_range(26, 31))
                                                          : t_letter'($urandom_range(0, 25));
            end
            // One phase runs on a key with equal columns, so its determinant is zero.
            if (phase == 2) begin
                rand_key[1] = rand_key[0];
                rand_key[3] = rand_key[2];
            end
            load_key(rand_key);
            repeat (PHASE_PAIRS) begin
                send_pair(pair_row(cipher_op_e'($urandom_range(0, 1)), rand_letter(),
                                   rand_letter(), ($urandom_range(0, 7) == 0)));
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
